### hw/rtl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by every module of the block.
package bsa_pkg;

   localparam int MAX_SLOTS  = 128;
   localparam int WORD_BITS  = 32;
   localparam int NUM_WORDS  = 4;
   localparam int STORE_BITS = NUM_WORDS * WORD_BITS;
   localparam int SLOT_LIMIT = (MAX_SLOTS < STORE_BITS) ? MAX_SLOTS : STORE_BITS;

   localparam int SLOT_W = 7;
   localparam int LIM_W  = SLOT_W + 1;
   localparam int CNT_W  = 8;
   localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int WIDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   localparam logic [2:0] MODE_ADD        = 3'd0;
   localparam logic [2:0] MODE_REMOVE     = 3'd1;
   localparam logic [2:0] MODE_QUERY      = 3'd2;
   localparam logic [2:0] MODE_FIRST_USED = 3'd3;
   localparam logic [2:0] MODE_NEXT_USED  = 3'd4;
   localparam logic [2:0] MODE_FIRST_FREE = 3'd5;
   localparam logic [2:0] MODE_CLEAR      = 3'd6;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [SLOT_W-1:0] slot_index;
   } req_payload_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] result_index;
      logic              slot_was_used;
      logic [CNT_W-1:0]  used_count;
   } rsp_payload_type;

   typedef struct packed {
      logic              set_en;
      logic              clr_en;
      logic              clr_all;
      logic [WIDX_W-1:0] word;
      logic [BIT_W-1:0]  bit_sel;
   } bmp_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

### hw/rtl/bitmap_slot_allocator.sv
// Bitmap slot allocator top level: sequencer, count and result register.
// Add, remove, query, clear, next used from the top slot: lookup then finish, no scan; one
// request in flight at a time. Searches scan one bitmap word per cycle through the shared
// scan unit, up to the last word or the first hit. A new request is taken while the previous
// result still waits. Synchronous reset clears the bitmap and count at once; no clearing pass.
// Depends on bsa_pkg, bsa_bitmap, bsa_word_scan.
module bitmap_slot_allocator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bsa_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bsa_pkg::rsp_payload_type rsp_payload
);
   import bsa_pkg::*;

   state_type         state_ff, state_in;
   logic [2:0]        mode_ff, mode_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [WIDX_W-1:0] word_ff, word_in;
   logic [BIT_W-1:0]  start_bit_ff, start_bit_in;
   logic              was_ff, was_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] where_ff, where_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [WIDX_W-1:0] rd_word;
   word_type          rd_data;
   bmp_ctrl_type      bmp_ctrl;
   logic              scan_hit;
   logic [BIT_W-1:0]  scan_pos;
   logic [WIDX_W-1:0] idx_word;
   logic [BIT_W-1:0]  idx_bit;
   logic              idx_in_range;
   logic              idx_used;
   logic [LIM_W-1:0]  start_next;
   logic              next_in_range;
   logic              want_used;
   logic              rsp_free;

   bsa_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (bmp_ctrl),
      .rd_word (rd_word),
      .rd_data (rd_data)
   );

   bsa_word_scan u_scan (
      .word      (rd_data),
      .word_sel  (rd_word),
      .start_bit (start_bit_ff),
      .want_used (want_used),
      .hit       (scan_hit),
      .hit_pos   (scan_pos)
   );

   always_comb begin
      idx_word      = WIDX_W'(idx_ff >> BIT_W);
      idx_bit       = idx_ff[BIT_W-1:0];
      idx_in_range  = LIM_W'(idx_ff) < LIM_W'(SLOT_LIMIT);
      idx_used      = idx_in_range & rd_data[idx_bit];
      start_next    = LIM_W'(idx_ff) + LIM_W'(1);
      next_in_range = start_next < LIM_W'(SLOT_LIMIT);
      want_used     = (mode_ff != MODE_FIRST_FREE);
      rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (mode_ff == MODE_FIRST_USED || mode_ff == MODE_FIRST_FREE) begin
               state_in = ST_SCAN;
            end else if (mode_ff == MODE_NEXT_USED && next_in_range) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (scan_hit || word_ff == WIDX_W'(NUM_WORDS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      mode_in          = mode_ff;
      idx_in           = idx_ff;
      word_in          = word_ff;
      start_bit_in     = start_bit_ff;
      was_in           = was_ff;
      found_in         = found_ff;
      where_in         = where_ff;
      total_in         = total_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rd_word          = word_ff;
      bmp_ctrl         = '0;
      bmp_ctrl.word    = idx_word;
      bmp_ctrl.bit_sel = idx_bit;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_payload.mode;
               idx_in  = req_payload.slot_index;
            end
         end
         ST_LOOKUP: begin
            rd_word      = idx_word;
            was_in       = idx_used;
            found_in     = 1'b0;
            where_in     = '0;
            word_in      = '0;
            start_bit_in = '0;
            case (mode_ff)
               MODE_ADD: begin
                  if (idx_in_range && !idx_used && total_ff < CNT_W'(MAX_SLOTS)) begin
                     bmp_ctrl.set_en = 1'b1;
                     total_in        = total_ff + CNT_W'(1);
                  end
               end
               MODE_REMOVE: begin
                  if (idx_used && total_ff != '0) begin
                     bmp_ctrl.clr_en = 1'b1;
                     total_in        = total_ff - CNT_W'(1);
                  end
               end
               MODE_CLEAR: begin
                  bmp_ctrl.clr_all = 1'b1;
                  total_in         = '0;
               end
               MODE_NEXT_USED: begin
                  word_in      = WIDX_W'(start_next >> BIT_W);
                  start_bit_in = start_next[BIT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_hit) begin
               found_in = 1'b1;
               where_in = SLOT_W'({word_ff, scan_pos});
            end else begin
               word_in      = WIDX_W'(word_ff + 1'b1);
               start_bit_in = '0;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.found         = found_ff;
               rsp_in.result_index  = where_ff;
               rsp_in.slot_was_used = was_ff;
               rsp_in.used_count    = total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      word_ff      <= word_in;
      start_bit_ff <= start_bit_in;
      was_ff       <= was_in;
      found_ff     <= found_in;
      where_ff     <= where_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in flight");

   assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_SLOTS))
      else $error("used count above slot maximum");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP && mode_ff == MODE_CLEAR |=> total_ff == '0)
      else $error("clear left a nonzero count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.result_index == '0)
      else $error("nonzero index without a found slot");

endmodule

### hw/rtl/bsa_word_scan.sv
// Shared scan unit: finds the lowest matching bit of one bitmap word.
// Depends on bsa_pkg.
module bsa_word_scan (
   input  bsa_pkg::word_type          word,
   input  logic [bsa_pkg::WIDX_W-1:0] word_sel,
   input  logic [bsa_pkg::BIT_W-1:0]  start_bit,
   input  logic                       want_used,
   output logic                       hit,
   output logic [bsa_pkg::BIT_W-1:0]  hit_pos
);
   import bsa_pkg::*;

   localparam word_type WORD_ONES = {WORD_BITS{1'b1}};

   word_type valid_mask;
   word_type cand;

   // keep only slots below the limit
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = ((int'(word_sel) * WORD_BITS + b) < SLOT_LIMIT);
      end
   end

   always_comb begin
      cand    = (want_used ? word : ~word) & valid_mask & word_type'(WORD_ONES << start_bit);
      hit     = |cand;
      hit_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            hit_pos = BIT_W'(b);
         end
      end
   end

endmodule

### hw/rtl/bsa_bitmap.sv
// Used-slot bitmap storage: one word read port, single-bit set and clear, clear all.
// Depends on bsa_pkg.
module bsa_bitmap (
   input  logic                       clock,
   input  logic                       reset,
   input  bsa_pkg::bmp_ctrl_type      ctrl,
   input  logic [bsa_pkg::WIDX_W-1:0] rd_word,
   output bsa_pkg::word_type          rd_data
);
   import bsa_pkg::*;

   word_type words_ff [NUM_WORDS];
   word_type words_in [NUM_WORDS];

   always_comb begin
      for (int w = 0; w < NUM_WORDS; w++) begin
         words_in[w] = words_ff[w];
      end
      if (ctrl.clr_all) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            words_in[w] = '0;
         end
      end else if (ctrl.set_en) begin
         words_in[ctrl.word][ctrl.bit_sel] = 1'b1;
      end else if (ctrl.clr_en) begin
         words_in[ctrl.word][ctrl.bit_sel] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
         if (reset) begin
            words_ff[w] <= '0;
         end else begin
            words_ff[w] <= words_in[w];
         end
      end
   end

   assign rd_data = words_ff[rd_word];

endmodule
